// ===== sv/ppgbr_pkg.sv =====
// Package for the optical beat and rate detector.
// Holds item structs, register indexes, constants and the control types.
// Used by every module of the block; depends on nothing.
package ppgbr_pkg;

    localparam int unsigned SAMPLE_W    = 18;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned STEP_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] CNT_MAX            = 16'hFFFF;
    localparam logic [CNT_W-1:0] BPM_SCALE          = 16'd60000;
    localparam logic [CNT_W-1:0] MIN_GAP_RESET      = 16'd10;
    localparam logic [CNT_W-1:0] RATE_WINDOW_RESET  = 16'd1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_WINDOW = 4'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ir_value;
        logic [TIME_W-1:0]   time_ms;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] bpm;
        logic             beat_seen;
        logic             rate_updated;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_finish;
        logic push;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic skid_full;
    } t_ctrl_status;

endpackage

// ===== sv/ppgbr_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Uses ppgbr_pkg for the result struct.
module ppgbr_out_buf import ppgbr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_push_data,
    output logic      o_skid_full,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_item r_skid_data;
    t_out_item n_skid_data;
    logic      pop;

    assign pop = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (pop) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_push) begin
            if ((!r_out_valid || pop) && !r_skid_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = i_push_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_push_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_skid_full = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/ppgbr_ctrl.sv =====
// Controller state machine: accepts items and sequences the serial divider.
// Uses ppgbr_pkg for the state, command and status types.
module ppgbr_ctrl import ppgbr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state                r_state;
    t_state                n_state;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [STEP_CNT_W-1:0] n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = i_status.skid_full;
                if (i_in_valid && !i_status.skid_full) begin
                    o_cmd.load = 1'b1;
                    if (i_status.need_div) begin
                        n_state = S_DIV;
                        n_cnt   = '0;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.div_finish = 1'b1;
                o_cmd.push       = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/ppgbr_datapath.sv =====
// Datapath: threshold tracking, beat test, window state and serial divider.
// Holds the configuration registers; uses ppgbr_pkg for types and constants.
module ppgbr_datapath import ppgbr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_in_item               i_in_data,
    input  t_ctrl_cmd              i_cmd,
    output logic                   o_need_div,
    output t_out_item              o_result
);

    logic [CNT_W-1:0]    r_min_gap;
    logic [CNT_W-1:0]    r_window;
    logic [SAMPLE_W-1:0] r_thr;
    logic [SAMPLE_W-1:0] r_prev;
    logic [CNT_W-1:0]    r_beats;
    logic [TIME_W-1:0]   r_wstart;
    logic [CNT_W-1:0]    r_gap;
    logic                r_disarmed;
    logic [CNT_W-1:0]    r_rate;
    logic [TIME_W-1:0]   r_num;
    logic [TIME_W-1:0]   r_den;
    logic [TIME_W-1:0]   r_rem;

    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    gap_inc;
    logic [SAMPLE_W-1:0] seed;
    logic [SAMPLE_W+3:0] thr_sum;
    logic [SAMPLE_W-1:0] thr_new;
    logic                rise;
    logic                beat;
    logic [CNT_W-1:0]    beats_inc;
    logic [TIME_W-1:0]   elapsed;
    logic                update;
    logic [TIME_W:0]     rem_sh;
    logic                q_bit;
    logic [CNT_W-1:0]    rate_sat;

    assign sample    = i_in_data.ir_value;
    assign gap_inc   = (r_gap != CNT_MAX) ? r_gap + 1'b1 : r_gap;
    assign seed      = (r_thr == '0) ? sample : r_thr;
    assign thr_sum   = ({1'b0, seed, 3'b000} - {4'b0000, seed}) + {4'b0000, sample};
    assign thr_new   = thr_sum[SAMPLE_W+2:3];
    assign rise      = (sample > r_prev) && (sample > thr_new) && !r_disarmed;
    assign beat      = rise && (gap_inc > r_min_gap);
    assign beats_inc = (r_beats != CNT_MAX) ? r_beats + 1'b1 : r_beats;
    assign elapsed   = i_in_data.time_ms - r_wstart;
    assign update    = beat && (elapsed > {{(TIME_W-CNT_W){1'b0}}, r_window});

    assign rem_sh    = {r_rem, r_num[TIME_W-1]};
    assign q_bit     = rem_sh >= {1'b0, r_den};
    assign rate_sat  = (r_num[TIME_W-1:CNT_W] != '0) ? CNT_MAX : r_num[CNT_W-1:0];

    assign o_need_div = update;

    always_comb begin
        if (i_cmd.div_finish) begin
            o_result.bpm          = rate_sat;
            o_result.beat_seen    = 1'b1;
            o_result.rate_updated = 1'b1;
        end else begin
            o_result.bpm          = r_rate;
            o_result.beat_seen    = beat;
            o_result.rate_updated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap  <= MIN_GAP_RESET;
            r_window   <= RATE_WINDOW_RESET;
            r_thr      <= '0;
            r_prev     <= '0;
            r_beats    <= '0;
            r_wstart   <= '0;
            r_gap      <= '0;
            r_disarmed <= 1'b0;
            r_rate     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MIN_GAP:     r_min_gap <= i_cfg_data;
                    CFG_RATE_WINDOW: r_window  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_thr  <= thr_new;
                r_prev <= sample;
                r_gap  <= beat ? '0 : gap_inc;
                if (rise) begin
                    if (beat) begin
                        r_disarmed <= 1'b1;
                    end
                end else if (sample < thr_new) begin
                    r_disarmed <= 1'b0;
                end
                if (beat) begin
                    r_beats <= update ? '0 : beats_inc;
                end
                if (update) begin
                    r_wstart <= i_in_data.time_ms;
                end
            end
            if (i_cmd.div_finish) begin
                r_rate <= rate_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= TIME_W'(beats_inc * BPM_SCALE);
            r_den <= elapsed;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[TIME_W-2:0], q_bit};
            r_rem <= q_bit ? TIME_W'(rem_sh - {1'b0, r_den}) : rem_sh[TIME_W-1:0];
        end
    end

endmodule

// ===== sv/ppg_beat_rate_detector.sv =====
// Top level of the optical beat and rate detector.
// Instantiates ppgbr_ctrl, ppgbr_datapath and ppgbr_out_buf; uses ppgbr_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in       input      i_in_valid/o_in_stall  t_in_item (ir_value, time_ms)
//   out      output     o_out_valid/i_out_stall t_out_item (bpm, beat_seen, rate_updated)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An item that does not recompute the rate is loaded and its result pushed in the same cycle.
// An item that recomputes the rate is loaded, then runs the serial 32-step restoring
// divider in S_DIV and a finish state S_FIN before its result is pushed; input stalls meanwhile.
// Reset is synchronous and active low; configuration is always ready.
// Results pass through an output register and a skid register, so input
// transfers continue while one result waits on a stalled output.
module ppg_beat_rate_detector import ppgbr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output t_out_item              o_out_data,
    input  logic                   i_out_stall,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_cfg_ready
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;
    t_out_item    result;
    logic         need_div;
    logic         skid_full;

    assign o_cfg_ready      = 1'b1;
    assign status.need_div  = need_div;
    assign status.skid_full = skid_full;

    ppgbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppgbr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_need_div  (need_div),
        .o_result    (result)
    );

    ppgbr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (cmd.push),
        .i_push_data (result),
        .o_skid_full (skid_full),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/sv/tb_ppg_beat_rate_detector.sv =====
// Self-checking testbench for ppg_beat_rate_detector, the optical beat and rate detector.
// A queue-fed driver and a monitor run against an in-bench beat and rate predictor.
// Depends on ppgbr_pkg and the ppg_beat_rate_detector RTL.
module tb_ppg_beat_rate_detector;
    import ppgbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT      = 26;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned MAX_SAMPLE    = 262143;
    localparam int unsigned LOW_LEVEL     = 1000;
    localparam int unsigned HIGH_LEVEL    = 200000;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW = CFG_RATE_WINDOW + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_TOP = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    t_in_item               in_data = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_item              o_out_data;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   o_cfg_ready;

    t_in_item  samples_to_send[$];
    t_out_item predicted_reports[$];
    logic      quiet = 1'b0;
    int        mismatches = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    // Predictor state, mirroring the detector after reset.
    logic [CNT_W-1:0]    min_gap_cfg = MIN_GAP_RESET;
    logic [CNT_W-1:0]    window_cfg = RATE_WINDOW_RESET;
    logic [SAMPLE_W-1:0] thresh = '0;
    logic [SAMPLE_W-1:0] last_sample = '0;
    logic [CNT_W-1:0]    beats_counted = '0;
    logic [TIME_W-1:0]   window_start = '0;
    logic [CNT_W-1:0]    since_beat = '0;
    logic                disarmed = 1'b0;
    logic [CNT_W-1:0]    bpm_now = '0;

    ppg_beat_rate_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item predict_report(input t_in_item smp);
        t_out_item rep;
        logic [21:0] mix;
        logic [TIME_W-1:0] elapsed;
        logic [63:0] rate;
        rep = '0;
        if (since_beat != CNT_MAX) since_beat = since_beat + 1'b1;
        if (thresh == '0) thresh = smp.ir_value;
        mix = 22'(thresh) * 22'd7 + 22'(smp.ir_value);
        thresh = mix[20:3];
        if (smp.ir_value > last_sample && smp.ir_value > thresh && !disarmed) begin
            if (since_beat > min_gap_cfg) begin
                if (beats_counted != CNT_MAX) beats_counted = beats_counted + 1'b1;
                since_beat = '0;
                disarmed = 1'b1;
                rep.beat_seen = 1'b1;
                elapsed = smp.time_ms - window_start;
                if (elapsed > TIME_W'(window_cfg)) begin
                    rate = 64'(beats_counted) * 64'(BPM_SCALE) / 64'(elapsed);
                    bpm_now = (rate > 64'(CNT_MAX)) ? CNT_MAX : rate[CNT_W-1:0];
                    beats_counted = '0;
                    window_start = smp.time_ms;
                    rep.rate_updated = 1'b1;
                end
            end
        end else if (smp.ir_value < thresh) begin
            disarmed = 1'b0;
        end
        last_sample = smp.ir_value;
        rep.bpm = bpm_now;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) predicted_reports.push_back(predict_report(in_data));
            if (!in_valid || !o_in_stall) begin
                if (samples_to_send.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_data <= samples_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : report_check
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (predicted_reports.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, %s %0d %0d %0d",
                             $time, "got bpm beat rate", o_out_data.bpm,
                             o_out_data.beat_seen, o_out_data.rate_updated);
                    mismatches++;
                end else begin
                    want = predicted_reports.pop_front();
                    if (o_out_data.bpm !== want.bpm) begin
                        $display("%0t: bpm expected %0d got %0d", $time, want.bpm, o_out_data.bpm);
                        mismatches++;
                    end
                    if (o_out_data.beat_seen !== want.beat_seen) begin
                        $display("%0t: beat_seen expected %0b got %0b",
                                 $time, want.beat_seen, o_out_data.beat_seen);
                        mismatches++;
                    end
                    if (o_out_data.rate_updated !== want.rate_updated) begin
                        $display("%0t: rate_updated expected %0b got %0b",
                                 $time, want.rate_updated, o_out_data.rate_updated);
                        mismatches++;
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MIN_GAP) min_gap_cfg = val;
        else if (idx == CFG_RATE_WINDOW) window_cfg = val;
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || in_valid || predicted_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [SAMPLE_W-1:0] v, input logic [TIME_W-1:0] t);
        t_in_item smp;
        smp.ir_value = v;
        smp.time_ms = t;
        samples_to_send.push_back(smp);
    endtask

    task automatic add_pairs(input int unsigned n, input int unsigned lo, input int unsigned hi,
                             input logic [TIME_W-1:0] step);
        for (int unsigned k = 0; k < n; k++) begin
            add_sample(SAMPLE_W'(lo), clock_ms);
            clock_ms += step;
            add_sample(SAMPLE_W'(hi), clock_ms);
        end
    endtask

    task automatic add_pulse_train(input int unsigned n);
        int unsigned base, amp, period, half, step, ph, rise, v;
        base = $urandom_range(0, 200000);
        amp = $urandom_range(2000, 60000);
        period = $urandom_range(2, 12);
        half = (period + 1) / 2;
        step = $urandom_range(0, 30);
        for (int unsigned k = 0; k < n; k++) begin
            ph = k % period;
            rise = (ph <= period / 2) ? ph : period - ph;
            v = base + amp * rise / half + $urandom_range(0, amp / 16);
            if (v > MAX_SAMPLE) v = MAX_SAMPLE;
            clock_ms += step + $urandom_range(0, 2);
            add_sample(SAMPLE_W'(v), clock_ms);
        end
    endtask

    initial begin
        #20_000_000;
        $display("FAIL ppg_beat_rate_detector");
        $finish;
    end

    initial begin
        int unsigned left, n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero threshold, reseeding after decay, field extremes, then two beats.
        add_sample('0, '0);
        add_sample(SAMPLE_W'(1), TIME_W'(5));
        add_sample('0, TIME_W'(6));
        add_sample('0, TIME_W'(7));
        add_sample(SAMPLE_W'(3), TIME_W'(8));
        add_sample(SAMPLE_W'(MAX_SAMPLE), '1);
        add_sample('0, TIME_W'(9));
        for (int unsigned k = 1; k <= 12; k++) begin
            add_sample(SAMPLE_W'(k * 17000), TIME_W'(100 + k * 150));
        end
        add_sample('0, TIME_W'(1500));
        add_sample('0, TIME_W'(1550));
        add_sample(SAMPLE_W'(250000), TIME_W'(1600));
        settle();

        // Zero window and gap, ignored register indexes, then saturated rate.
        write_reg(CFG_MIN_GAP, '0);
        write_reg(CFG_RATE_WINDOW, '0);
        write_reg(CFG_UNUSED_LOW, 16'h0005);
        write_reg(CFG_UNUSED_TOP, 16'hFFFF);
        clock_ms = 3000;
        add_pairs(2, LOW_LEVEL, HIGH_LEVEL, 1);
        settle();
        write_reg(CFG_RATE_WINDOW, 16'd1);
        add_pairs(2, LOW_LEVEL, HIGH_LEVEL, 0);
        add_pairs(1, LOW_LEVEL, HIGH_LEVEL, 2);
        settle();

        // A stretch without idling, beats inside one wide window, then a rate update.
        quiet = 1'b1;
        write_reg(CFG_RATE_WINDOW, CNT_MAX);
        clock_ms = window_start + 5;
        add_pairs(10, LOW_LEVEL, HIGH_LEVEL, 0);
        add_pairs(1, LOW_LEVEL, HIGH_LEVEL, 70000);
        settle();
        quiet = 1'b0;

        // Random rounds start close to the timestamp wrap.
        clock_ms = 32'hFFFF_F000;
        for (int round = 0; round < 10; round++) begin
            case ($urandom_range(0, 7))
                0: write_reg(CFG_MIN_GAP, '0);
                1: write_reg(CFG_MIN_GAP, CNT_MAX);
                default: write_reg(CFG_MIN_GAP, CFG_DATA_W'($urandom_range(1, 12)));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(CFG_RATE_WINDOW, '0);
                1: write_reg(CFG_RATE_WINDOW, CNT_MAX);
                default: write_reg(CFG_RATE_WINDOW, CFG_DATA_W'($urandom_range(1, 400)));
            endcase
            left = 40;
            while (left > 0) begin
                if ($urandom_range(0, 4) != 0) begin
                    n = $urandom_range(8, 20);
                    if (n > left) n = left;
                    add_pulse_train(n);
                end else begin
                    n = $urandom_range(1, 4);
                    if (n > left) n = left;
                    for (int unsigned k = 0; k < n; k++) begin
                        if ($urandom_range(0, 3) == 0) clock_ms += $urandom;
                        add_sample(SAMPLE_W'($urandom_range(0, MAX_SAMPLE)), $urandom);
                    end
                end
                left -= n;
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS ppg_beat_rate_detector");
        end else begin
            $display("FAIL ppg_beat_rate_detector");
        end
        $finish;
    end

endmodule

// ===== ppg_beat_rate_detector.f =====
sv/ppgbr_pkg.sv
sv/ppgbr_out_buf.sv
sv/ppgbr_ctrl.sv
sv/ppgbr_datapath.sv
sv/ppg_beat_rate_detector.sv
tb/sv/tb_ppg_beat_rate_detector.sv
